[src/ins_pkg.sv]
// ----------------------------------------------------------------------------
// ins_pkg
// Shared types and constants for the insertion sorter and its cell chain.
// ----------------------------------------------------------------------------
package ins_pkg;

  // default number of cells in the chain
  localparam int unsigned DEPTH_DEF = 16;

  // width of one sorted element
  localparam int unsigned VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  // controller state: collecting a set or emitting it
  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctl_t;

endpackage

[src/ins_if.sv]
// ----------------------------------------------------------------------------
// ins_if
// Valid/ready channel interfaces for the sorter's input and result words.
// ----------------------------------------------------------------------------
interface ins_in_if;
  logic              valid;
  logic              ready;
  ins_pkg::value_t   value;
  logic              last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface ins_out_if;
  logic              valid;
  logic              ready;
  ins_pkg::value_t   value_res;
  logic              last_res;
  logic              overflow;

  modport source (output valid, output value_res, output last_res, output overflow,
                  input ready);
  modport sink   (input valid, input value_res, input last_res, input overflow,
                  output ready);
endinterface

[src/ins_cell.sv]
// ----------------------------------------------------------------------------
// ins_cell
// One slot of the sorting chain: compares its element against the broadcast
// word, makes room by taking its left neighbor's element, or shifts left
// during readout.
// ----------------------------------------------------------------------------
module ins_cell (
  input  logic              clk,
  input  ins_pkg::cell_ctl_t ctl,
  input  ins_pkg::value_t   new_value,
  input  ins_pkg::value_t   left_value,
  input  logic              left_gt,
  input  logic              occupied,
  input  ins_pkg::value_t   right_value,
  output ins_pkg::value_t   value,
  output logic              gt
);
  import ins_pkg::*;

  // an empty slot counts as larger than anything; equal keeps its place
  assign gt = !occupied || (value > new_value);

  // insert: take the new word at the boundary, the left element past it
  always_ff @(posedge clk) begin
    if (ctl.ins && gt) begin
      value <= left_gt ? left_value : new_value;
    end else if (ctl.shift) begin
      value <= right_value;
    end
  end

endmodule

[src/insertion_sorter.sv]
// ----------------------------------------------------------------------------
// insertion_sorter
// Stable ascending sort of signed 32-bit words over a chain of DEPTH cells.
// ----------------------------------------------------------------------------
// Input words are taken one per cycle while a set is being collected: every
// cell compares its element with the incoming word in the same cycle and the
// larger elements move one cell to the right, so the chain stays sorted and
// equal words keep arrival order. The word marked last closes the set; the
// input then stalls while the chain shifts left one cell per output word.
// Cell 0 is the output register. Words that arrive while all DEPTH cells are
// full are dropped and every result of that set carries overflow. last_res
// marks the final word of the set.
// ----------------------------------------------------------------------------
module insertion_sorter #(
  parameter int unsigned DEPTH = ins_pkg::DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  ins_in_if.sink    din,
  ins_out_if.source dout
);
  import ins_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             ovf, ovf_next;

  logic      in_acc, out_acc, full;
  cell_ctl_t ctl;

  value_t cell_value [DEPTH];
  logic   cell_gt    [DEPTH];

  assign in_acc  = din.valid && din.ready;
  assign out_acc = dout.valid && dout.ready;
  assign full    = (count == CNT_W'(DEPTH));

  assign ctl.ins   = in_acc && !full;
  assign ctl.shift = out_acc;

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    value_t lv;
    logic   lg;
    value_t rv;

    if (i == 0) begin : g_first
      assign lv = din.value;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lv = cell_value[i-1];
      assign lg = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign rv = cell_value[i];
    end else begin : g_body
      assign rv = cell_value[i+1];
    end

    ins_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .new_value   (din.value),
      .left_value  (lv),
      .left_gt     (lg),
      .occupied    (CNT_W'(i) < count),
      .right_value (rv),
      .value       (cell_value[i]),
      .gt          (cell_gt[i])
    );
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
    end
  end

  // next state and fill bookkeeping
  always_comb begin
    state_next = state;
    count_next = count;
    ovf_next   = ovf;
    case (state)
      ST_FILL: begin
        if (in_acc) begin
          if (full) begin
            ovf_next = 1'b1;
          end else begin
            count_next = count + CNT_W'(1);
          end
          if (din.last) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_acc) begin
          count_next = count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            state_next = ST_FILL;
            ovf_next   = 1'b0;
          end
        end
      end
      default: begin
        state_next = ST_FILL;
      end
    endcase
  end

  // handshake and result word
  assign din.ready      = (state == ST_FILL);
  assign dout.valid     = (state == ST_DRAIN);
  assign dout.value_res = cell_value[0];
  assign dout.last_res  = (count == CNT_W'(1));
  assign dout.overflow  = ovf;

  // checks
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> count != '0)
    else $error("draining with an empty chain");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL && ovf) |-> full)
    else $error("overflow flagged while chain not full");

  a_last_ends_set: assert property (@(posedge clk) disable iff (rst)
    (out_acc && dout.last_res) |=> (din.ready && count == '0 && !ovf))
    else $error("set not closed after final word");

endmodule
